### src/e2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch to calendar package
// Field widths, division constants and the month table shared by the
// epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam int unsigned NUM_STAGES = 11;

    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned YEAR_W  = 8;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned TOD_W   = 17;
    localparam int unsigned DOY_W   = 9;

    typedef logic [DAYS_W-1:0] t_days;
    typedef logic [TOD_W-1:0]  t_tod;

    // Reciprocals are floor(2^k / divisor); one correction step follows each.
    localparam logic [25:0] DAY_RECIP        = 26'd50903316;  // 2^35 / 675
    localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
    localparam logic [15:0] DAYS_PER_CENTURY = 16'd36525;
    localparam logic [15:0] QUAD_RECIP       = 16'd45933;     // 2^26 / 1461
    localparam logic [10:0] DAYS_PER_QUAD    = 11'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
    localparam logic [8:0]  HOUR_RECIP       = 9'd291;        // 2^16 / 225
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
    localparam logic [8:0]  MIN_RECIP        = 9'd273;        // 2^12 / 15
    localparam logic [5:0]  SECS_PER_MIN     = 6'd60;

    // First day of each month counted from March 1, March being index zero.
    function automatic logic [DOY_W-1:0] mar_month_start(input logic [3:0] idx);
        logic [DOY_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### src/e2c_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch input channel
// Valid/ready channel that carries one timestamp per transaction.
// ----------------------------------------------------------------------------
interface e2c_in_if
    import e2c_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

### src/e2c_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar output channel
// Valid/ready channel that carries one broken-down date and time per
// transaction.
// ----------------------------------------------------------------------------
interface e2c_out_if
    import e2c_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_offset;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;

    modport source (output valid, output year_offset, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year_offset, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

### src/epoch_seconds_to_calendar_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Converts seconds since 2000-01-01 00:00:00 into year offset, month, day,
// hour, minute and second.
//
// The timestamp arrives on the i_ts channel and the broken-down date and time
// leave on the o_cal channel, one result transaction for every input
// transaction, in order. The block is an eleven-stage pipeline, and a new
// timestamp can be accepted in every cycle unless the output is stalled.
// Three stages split the count into whole days and seconds of the day; the
// date and time of day then proceed in two parallel eight-stage pipelines.
// The depth is set by the reciprocal multipliers and their correction steps.
// Reset clears the stage valid bits; the data registers are not reset.
// When the receiver holds ready low while a result is waiting, the whole
// pipeline freezes and i_ts.ready drops in the same cycle, so nothing is lost
// or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
    import e2c_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    e2c_in_if.sink       i_ts,
    e2c_out_if.source    o_cal
);

    logic                  w_en;
    logic [50:0]           w_prod1;
    logic [32:0]           w_prod2;
    logic [32:0]           w_rem2;

    logic [NUM_STAGES-1:0] r_vld;
    logic [EPOCH_W-1:0]    r_s1_secs;
    t_days                 r_s1_days;
    t_days                 r_s2_days;
    logic [17:0]           r_s2_rem, n_s2_rem;
    t_days                 r_s3_days, n_s3_days;
    t_tod                  r_s3_tod, n_s3_tod;

    assign w_en       = !r_vld[NUM_STAGES-1] || o_cal.ready;
    assign i_ts.ready = w_en;
    assign o_cal.valid = r_vld[NUM_STAGES-1];

    assign w_prod1 = i_ts.epoch_seconds[EPOCH_W-1:7] * DAY_RECIP;
    assign w_prod2 = r_s1_days * SECS_PER_DAY;
    assign w_rem2  = {1'b0, r_s1_secs} - w_prod2;

    always_comb begin
        n_s2_rem = w_rem2[17:0];
        if (r_s2_rem >= {1'b0, SECS_PER_DAY}) begin
            n_s3_days = r_s2_days + 16'd1;
            n_s3_tod  = 17'(r_s2_rem - {1'b0, SECS_PER_DAY});
        end else begin
            n_s3_days = r_s2_days;
            n_s3_tod  = r_s2_rem[TOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_ts.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_secs <= i_ts.epoch_seconds;
            r_s1_days <= w_prod1[50:35];
            r_s2_days <= r_s1_days;
            r_s2_rem  <= n_s2_rem;
            r_s3_days <= n_s3_days;
            r_s3_tod  <= n_s3_tod;
        end
    end

    e2c_date u_date (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_days         (r_s3_days),
        .o_year_offset  (o_cal.year_offset),
        .o_month        (o_cal.month),
        .o_day_of_month (o_cal.day_of_month)
    );

    e2c_tod u_tod (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_tod    (r_s3_tod),
        .o_hour   (o_cal.hour),
        .o_minute (o_cal.minute),
        .o_second (o_cal.second)
    );

`ifndef SYNTH
    a_month_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.month >= 4'd1 && o_cal.month <= 4'd12))
        else $error("Month out of range.");

    a_feb_days : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cal.valid && o_cal.month == 4'd2) |-> (o_cal.day_of_month <= 5'd29))
        else $error("February day beyond 29.");

    a_date_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.day_of_month >= 5'd1 && o_cal.year_offset <= 8'd136))
        else $error("Day or year out of range.");

    a_time_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.hour <= 5'd23 && o_cal.minute <= 6'd59
                         && o_cal.second <= 6'd59))
        else $error("Time of day out of range.");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("Pipeline moved during a stall.");
`endif

endmodule
`default_nettype wire

### src/e2c_tod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day splitter
// Eight-stage pipeline that splits seconds of the day into hour, minute and
// second by reciprocal multiplication with one correction step each.
// ----------------------------------------------------------------------------
module e2c_tod
    import e2c_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_tod              i_tod,
    output logic [HOUR_W-1:0]      o_hour,
    output logic [MIN_W-1:0]       o_minute,
    output logic [SEC_W-1:0]       o_second
);

    logic [21:0]       w_ph;
    logic [16:0]       w_hsub;
    logic [18:0]       w_pm;
    logic [11:0]       w_msub;

    t_tod              r_a_tod, n_a_tod;
    logic [HOUR_W-1:0] r_a_hr, n_a_hr;
    logic [HOUR_W-1:0] r_b_hr, n_b_hr;
    logic [12:0]       r_b_rem, n_b_rem;
    logic [HOUR_W-1:0] r_c_hr, n_c_hr;
    logic [11:0]       r_c_rem, n_c_rem;
    logic [HOUR_W-1:0] r_d_hr, n_d_hr;
    logic [11:0]       r_d_rem, n_d_rem;
    logic [MIN_W-1:0]  r_d_min, n_d_min;
    logic [HOUR_W-1:0] r_e_hr, n_e_hr;
    logic [MIN_W-1:0]  r_e_min, n_e_min;
    logic [6:0]        r_e_sec, n_e_sec;
    logic [HOUR_W-1:0] r_f_hr, n_f_hr;
    logic [MIN_W-1:0]  r_f_min, n_f_min;
    logic [SEC_W-1:0]  r_f_sec, n_f_sec;
    logic [HOUR_W-1:0] r_g_hr;
    logic [MIN_W-1:0]  r_g_min;
    logic [SEC_W-1:0]  r_g_sec;
    logic [HOUR_W-1:0] r_h_hr;
    logic [MIN_W-1:0]  r_h_min;
    logic [SEC_W-1:0]  r_h_sec;

    assign w_ph   = i_tod[TOD_W-1:4] * HOUR_RECIP;
    assign w_hsub = r_a_hr * SECS_PER_HOUR;
    assign w_pm   = r_c_rem[11:2] * MIN_RECIP;
    assign w_msub = r_d_min * SECS_PER_MIN;

    always_comb begin
        n_a_tod = i_tod;
        n_a_hr  = w_ph[20:16];

        n_b_hr  = r_a_hr;
        n_b_rem = 13'(r_a_tod - w_hsub);

        if (r_b_rem >= {1'b0, SECS_PER_HOUR}) begin
            n_c_hr  = r_b_hr + 5'd1;
            n_c_rem = 12'(r_b_rem - {1'b0, SECS_PER_HOUR});
        end else begin
            n_c_hr  = r_b_hr;
            n_c_rem = r_b_rem[11:0];
        end

        n_d_hr  = r_c_hr;
        n_d_rem = r_c_rem;
        n_d_min = w_pm[17:12];

        n_e_hr  = r_d_hr;
        n_e_min = r_d_min;
        n_e_sec = 7'(r_d_rem - w_msub);

        if (r_e_sec >= {1'b0, SECS_PER_MIN}) begin
            n_f_min = r_e_min + 6'd1;
            n_f_sec = 6'(r_e_sec - {1'b0, SECS_PER_MIN});
        end else begin
            n_f_min = r_e_min;
            n_f_sec = r_e_sec[SEC_W-1:0];
        end
        n_f_hr = r_e_hr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tod <= n_a_tod;
            r_a_hr  <= n_a_hr;
            r_b_hr  <= n_b_hr;
            r_b_rem <= n_b_rem;
            r_c_hr  <= n_c_hr;
            r_c_rem <= n_c_rem;
            r_d_hr  <= n_d_hr;
            r_d_rem <= n_d_rem;
            r_d_min <= n_d_min;
            r_e_hr  <= n_e_hr;
            r_e_min <= n_e_min;
            r_e_sec <= n_e_sec;
            r_f_hr  <= n_f_hr;
            r_f_min <= n_f_min;
            r_f_sec <= n_f_sec;
            r_g_hr  <= r_f_hr;
            r_g_min <= r_f_min;
            r_g_sec <= r_f_sec;
            r_h_hr  <= r_g_hr;
            r_h_min <= r_g_min;
            r_h_sec <= r_g_sec;
        end
    end

    assign o_hour   = r_h_hr;
    assign o_minute = r_h_min;
    assign o_second = r_h_sec;

endmodule
`default_nettype wire

### src/e2c_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Day count to date
// Eight-stage pipeline that places a day count in the century and four-year
// cycles, then in a year, and finally resolves month and day of month.
// ----------------------------------------------------------------------------
module e2c_date
    import e2c_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_days             i_days,
    output logic [YEAR_W-1:0]      o_year_offset,
    output logic [MONTH_W-1:0]     o_month,
    output logic [DAY_W-1:0]       o_day_of_month
);

    logic [31:0]        w_pq;
    logic [15:0]        w_qsub;
    logic [10:0]        w_d9;
    logic [10:0]        w_ysub;
    logic [2:0]         w_yinc;
    logic [DOY_W-1:0]   w_jf;
    logic [3:0]         w_k;
    logic               w_big;
    logic [DOY_W-1:0]   w_dsub;

    logic               r_a_cen, n_a_cen;
    t_days              r_a_rem, n_a_rem;
    logic               r_b_cen;
    t_days              r_b_rem;
    logic [4:0]         r_b_quad, n_b_quad;
    logic               r_c_cen;
    logic [4:0]         r_c_quad;
    logic [11:0]        r_c_rem, n_c_rem;
    logic [YEAR_W-1:0]  r_d_year, n_d_year;
    logic [10:0]        r_d_rem, n_d_rem;
    logic [YEAR_W-1:0]  r_e_year;
    logic [10:0]        r_e_dq, n_e_dq;
    logic               r_e_leap, n_e_leap;
    logic [YEAR_W-1:0]  r_f_year, n_f_year;
    logic [DOY_W-1:0]   r_f_doy, n_f_doy;
    logic               r_f_leap, n_f_leap;
    logic [YEAR_W-1:0]  r_g_year;
    logic               r_g_jf, n_g_jf;
    logic [DOY_W-1:0]   r_g_d, n_g_d;
    logic [YEAR_W-1:0]  r_h_year;
    logic [MONTH_W-1:0] r_h_mon, n_h_mon;
    logic [DAY_W-1:0]   r_h_day, n_h_day;

    assign w_pq   = r_a_rem * QUAD_RECIP;
    assign w_qsub = r_b_quad * DAYS_PER_QUAD;

    always_comb begin
        if (i_days >= DAYS_PER_CENTURY) begin
            n_a_cen = 1'b1;
            n_a_rem = i_days - DAYS_PER_CENTURY;
        end else begin
            n_a_cen = 1'b0;
            n_a_rem = i_days;
        end

        n_b_quad = w_pq[30:26];

        n_c_rem = 12'(r_b_rem - w_qsub);

        if (r_c_rem >= {1'b0, DAYS_PER_QUAD}) begin
            n_d_rem  = 11'(r_c_rem - {1'b0, DAYS_PER_QUAD});
            n_d_year = (r_c_cen ? 8'd100 : 8'd0) + {1'b0, 5'(r_c_quad + 5'd1), 2'b00};
        end else begin
            n_d_rem  = r_c_rem[10:0];
            n_d_year = (r_c_cen ? 8'd100 : 8'd0) + {1'b0, r_c_quad, 2'b00};
        end

        n_e_dq   = r_d_rem + {10'd0, (r_d_year > 8'd100)};
        n_e_leap = (r_d_year != 8'd100);

        // Past the first (leap) year of the cycle the rest are common years.
        w_d9 = r_e_dq - {10'd0, r_e_leap};
        if (w_d9 >= 11'd1460) begin
            w_yinc = 3'd4;
            w_ysub = 11'd1460;
        end else if (w_d9 >= 11'd1095) begin
            w_yinc = 3'd3;
            w_ysub = 11'd1095;
        end else if (w_d9 >= 11'd730) begin
            w_yinc = 3'd2;
            w_ysub = 11'd730;
        end else if (w_d9 >= {2'b00, DAYS_PER_YEAR}) begin
            w_yinc = 3'd1;
            w_ysub = {2'b00, DAYS_PER_YEAR};
        end else begin
            w_yinc = 3'd0;
            w_ysub = 11'd0;
        end
        if (r_e_dq > (11'd364 + {10'd0, r_e_leap})) begin
            n_f_year = r_e_year + {5'd0, w_yinc};
            n_f_doy  = 9'(w_d9 - w_ysub);
            n_f_leap = 1'b0;
        end else begin
            n_f_year = r_e_year;
            n_f_doy  = r_e_dq[DOY_W-1:0];
            n_f_leap = r_e_leap;
        end

        w_jf = 9'd59 + {8'd0, r_f_leap};
        if (r_f_doy < w_jf) begin
            n_g_jf = 1'b1;
            n_g_d  = r_f_doy;
        end else begin
            n_g_jf = 1'b0;
            n_g_d  = r_f_doy - w_jf;
        end

        w_k = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (r_g_d >= mar_month_start(4'(i))) begin
                w_k = 4'(i);
            end
        end
        w_big = (r_g_d >= 9'd31);
        if (r_g_jf) begin
            w_dsub  = r_g_d - (w_big ? 9'd31 : 9'd0);
            n_h_mon = w_big ? 4'd2 : 4'd1;
        end else begin
            w_dsub  = r_g_d - mar_month_start(w_k);
            n_h_mon = 4'd3 + w_k;
        end
        n_h_day = 5'(w_dsub + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cen  <= n_a_cen;
            r_a_rem  <= n_a_rem;
            r_b_cen  <= r_a_cen;
            r_b_rem  <= r_a_rem;
            r_b_quad <= n_b_quad;
            r_c_cen  <= r_b_cen;
            r_c_quad <= r_b_quad;
            r_c_rem  <= n_c_rem;
            r_d_year <= n_d_year;
            r_d_rem  <= n_d_rem;
            r_e_year <= r_d_year;
            r_e_dq   <= n_e_dq;
            r_e_leap <= n_e_leap;
            r_f_year <= n_f_year;
            r_f_doy  <= n_f_doy;
            r_f_leap <= n_f_leap;
            r_g_year <= r_f_year;
            r_g_jf   <= n_g_jf;
            r_g_d    <= n_g_d;
            r_h_year <= r_g_year;
            r_h_mon  <= n_h_mon;
            r_h_day  <= n_h_day;
        end
    end

    assign o_year_offset  = r_h_year;
    assign o_month        = r_h_mon;
    assign o_day_of_month = r_h_day;

endmodule
`default_nettype wire

### verif/e2c_calendar_check.sv
// ----------------------------------------------------------------------------
// Calendar result checker
// Watches the timestamp and calendar channels of the converter, predicts the
// broken-down date and time of every accepted timestamp and compares each
// accepted result, field by field and in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module e2c_calendar_check
    import e2c_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    e2c_in_if    i_ts,
    e2c_out_if   i_cal,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_IN_DAY     = 86400;
    localparam int unsigned DAYS_IN_CENTURY = 36525;
    localparam int unsigned DAYS_IN_QUAD    = 1461;
    localparam int unsigned DAYS_IN_YEAR    = 365;
    localparam int unsigned DAYS_IN_HALF    = 153;
    localparam int unsigned DAYS_IN_PAIR    = 61;
    localparam int unsigned DAYS_IN_LONG    = 31;
    localparam int unsigned DAYS_JAN_FEB    = 59;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_offset;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_calendar;

    t_calendar pending_dates[$];
    int        error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_dates.size();

    // Years 2000 to 2136: century cycles, then leap cycles, then years; 2100
    // loses its leap day, so every later leap cycle starts one day early.
    function automatic t_calendar to_calendar(input logic [EPOCH_W-1:0] secs);
        int unsigned days;
        int unsigned years;
        int unsigned leap;
        int unsigned mon;
        t_calendar   cal;
        days  = secs / SECS_IN_DAY;
        years = 100 * (days / DAYS_IN_CENTURY);
        days  = days % DAYS_IN_CENTURY;
        years += 4 * (days / DAYS_IN_QUAD);
        days  = days % DAYS_IN_QUAD;
        if (years > 100) begin
            days++;
        end
        leap = (years == 100) ? 0 : 1;
        if (days > DAYS_IN_YEAR - 1 + leap) begin
            days  -= leap;
            leap  = 0;
            years += days / DAYS_IN_YEAR;
            days  = days % DAYS_IN_YEAR;
        end
        if (days < DAYS_JAN_FEB + leap) begin
            mon = days / DAYS_IN_LONG;
        end else begin
            days -= DAYS_JAN_FEB + leap;
            mon  = 2 + 5 * (days / DAYS_IN_HALF);
            days = days % DAYS_IN_HALF;
            mon  += 2 * (days / DAYS_IN_PAIR);
            days = days % DAYS_IN_PAIR;
            mon  += days / DAYS_IN_LONG;
        end
        cal.year_offset  = YEAR_W'(years);
        cal.month        = MONTH_W'(mon + 1);
        cal.day_of_month = DAY_W'(days % DAYS_IN_LONG + 1);
        cal.hour         = HOUR_W'((secs / 3600) % 24);
        cal.minute       = MIN_W'((secs / 60) % 60);
        cal.second       = SEC_W'(secs % 60);
        return cal;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n) begin
            if (i_ts.valid && i_ts.ready) begin
                pending_dates.push_back(to_calendar(i_ts.epoch_seconds));
            end
            if (i_cal.valid && i_cal.ready) begin
                if (pending_dates.size() == 0) begin
                    error_count++;
                    $display({"%0t: result transaction with none expected, ",
                              "actual %0d-%0d-%0d %0d:%0d:%0d"},
                             $time, i_cal.year_offset, i_cal.month, i_cal.day_of_month,
                             i_cal.hour, i_cal.minute, i_cal.second);
                end else begin
                    want = pending_dates.pop_front();
                    compare_field("year_offset", want.year_offset, i_cal.year_offset);
                    compare_field("month", want.month, i_cal.month);
                    compare_field("day_of_month", want.day_of_month, i_cal.day_of_month);
                    compare_field("hour", want.hour, i_cal.hour);
                    compare_field("minute", want.minute, i_cal.minute);
                    compare_field("second", want.second, i_cal.second);
                end
            end
        end
    end
endmodule

### verif/tb_epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter testbench
// Sends directed corner timestamps and random timestamps weighted toward day,
// leap-cycle and century boundaries through four idling phases, and leaves
// prediction and comparison to the calendar checker beside the converter.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_unit;
    import e2c_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PHASE_ITEMS = 307;
    localparam int unsigned MAX_DAY     = 49710;
    localparam int unsigned MAX_QUAD    = 33;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [EPOCH_W-1:0] DAY_SECS = 32'd86400;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          cycle_count    = 0;
    int          error_count;
    int          pending_count;

    logic [EPOCH_W-1:0] corner_ts[24] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd59 * DAY_SECS, 32'd60 * DAY_SECS, 32'd365 * DAY_SECS,
        32'd366 * DAY_SECS, 32'd1461 * DAY_SECS,
        32'd36524 * DAY_SECS + DAY_SECS - 1, 32'd36525 * DAY_SECS,
        32'd36583 * DAY_SECS, 32'd36584 * DAY_SECS, 32'd36889 * DAY_SECS,
        32'd36890 * DAY_SECS, 32'd38044 * DAY_SECS,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };

    e2c_in_if  ts_bus ();
    e2c_out_if cal_bus ();

    epoch_seconds_to_calendar_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ts    (ts_bus),
        .o_cal   (cal_bus)
    );

    e2c_calendar_check u_calendar_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ts      (ts_bus),
        .i_cal     (cal_bus),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cal_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_epoch_seconds_to_calendar_unit: errors");
            $finish;
        end
    end

    task automatic send_timestamp(input logic [EPOCH_W-1:0] secs);
        while ($urandom_range(99) < send_idle_pct) begin
            ts_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        ts_bus.valid         <= 1'b1;
        ts_bus.epoch_seconds <= secs;
        do @(posedge i_clk); while (!ts_bus.ready);
    endtask

    task automatic send_random_timestamp();
        logic [EPOCH_W-1:0] secs;
        int unsigned        day;
        int unsigned        near_days[10] = '{0, 58, 59, 60, 364, 365, 366, 730, 1095, 1460};
        case ($urandom_range(3))
            0: secs = $urandom();
            1: begin
                day  = $urandom_range(MAX_DAY);
                secs = day * DAY_SECS;
                case ($urandom_range(2))
                    0: secs = secs + DAY_SECS - 1;
                    1: secs = secs + $urandom_range(DAY_SECS - 1);
                    default: ;
                endcase
            end
            2: begin
                // Near a year or end-of-February boundary in a leap cycle, up to one day either side at random.
                day  = $urandom_range(MAX_QUAD) * 1461 + near_days[$urandom_range(9)];
                day  = day + $urandom_range(2) - 1;
                secs = day * DAY_SECS + $urandom_range(DAY_SECS - 1);
            end
            default: secs = 32'hFFFF_FFFF - $urandom_range(2000000);
        endcase
        send_timestamp(secs);
    endtask

    initial begin
        int wait_cycles;
        i_rst_n              <= 1'b0;
        ts_bus.valid         <= 1'b0;
        ts_bus.epoch_seconds <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_ts[k]) begin
            send_timestamp(corner_ts[k]);
        end
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            repeat (PHASE_ITEMS) send_random_timestamp();
        end
        ts_bus.valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        wait_cycles = NUM_STAGES + 8;
        repeat (wait_cycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_epoch_seconds_to_calendar_unit: clean");
        end else begin
            $display("tb_epoch_seconds_to_calendar_unit: errors");
        end
        $finish;
    end
endmodule
